// File: rtl/stok_pkg.sv
// ----------------------------------------------------------------------------
// stok_pkg: shared types and constants of the source tokenizer
// Token codes, result word layout, keyword and operator tables.
// ----------------------------------------------------------------------------
package stok_pkg;

  // Sizes
  localparam int KwMaxChars = 6;
  localparam int KwBits     = KwMaxChars * 8;
  localparam int OffsetBits = 32;
  localparam int KwCount    = 13;
  localparam int FifoDepth  = 4;
  localparam int PtrBits    = $clog2(FifoDepth);
  localparam int CntBits    = $clog2(FifoDepth + 1);

  localparam logic [30:0] ValueMax = 31'h7FFF_FFFF;
  localparam logic [23:0] LineMax  = 24'hFF_FFFF;
  localparam logic [15:0] LenMax   = 16'hFFFF;

  // Character codes
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowB  = 8'h62;
  localparam logic [7:0] ChUnder = 8'h5F;

  typedef enum logic [5:0] {
    KIND_NUM        = 6'd0,
    KIND_BOOL       = 6'd1,
    KIND_STRING     = 6'd2,
    KIND_MODULE     = 6'd3,
    KIND_INPUT      = 6'd4,
    KIND_OUTPUT     = 6'd5,
    KIND_IF         = 6'd6,
    KIND_ELIF       = 6'd7,
    KIND_ELSE       = 6'd8,
    KIND_WHILE      = 6'd9,
    KIND_PRINT      = 6'd10,
    KIND_IDENTIFIER = 6'd11,
    KIND_NUMBER     = 6'd12,
    KIND_TRUE       = 6'd13,
    KIND_FALSE      = 6'd14,
    KIND_ADD        = 6'd15,
    KIND_SUBTRACT   = 6'd16,
    KIND_MULTIPLY   = 6'd17,
    KIND_DIVIDE     = 6'd18,
    KIND_LOGICAND   = 6'd19,
    KIND_LOGICOR    = 6'd20,
    KIND_BITAND     = 6'd21,
    KIND_BITOR      = 6'd22,
    KIND_XOR        = 6'd23,
    KIND_NOT        = 6'd24,
    KIND_ASSIGN     = 6'd25,
    KIND_EQUALITY   = 6'd26,
    KIND_NE         = 6'd27,
    KIND_LT         = 6'd28,
    KIND_GT         = 6'd29,
    KIND_LTE        = 6'd30,
    KIND_GTE        = 6'd31,
    KIND_LPAREN     = 6'd32,
    KIND_RPAREN     = 6'd33,
    KIND_LBRACE     = 6'd34,
    KIND_RBRACE     = 6'd35,
    KIND_COMMA      = 6'd36,
    KIND_SEMICOLON  = 6'd37,
    KIND_EOF        = 6'd38,
    KIND_UNKNOWN    = 6'd39
  } kind_e;

  // One result word
  typedef struct packed {
    kind_e        kind;
    logic [30:0]  value;
    logic [31:0]  start;
    logic [15:0]  len;
    logic [23:0]  line;
    logic         last;
  } token_t;

  // Words produced by one accepted byte, first word in tok0
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } push_t;

  // Keyword table, text right-aligned and zero padded
  localparam logic [KwBits-1:0] KwText [KwCount] = '{
    "num", "bool", "string", "module", "input", "output",
    "if", "elif", "else", "while", "print", "true", "false"
  };
  localparam logic [3:0] KwLen [KwCount] = '{
    4'd3, 4'd4, 4'd6, 4'd6, 4'd5, 4'd6, 4'd2, 4'd4, 4'd4, 4'd5, 4'd5, 4'd4, 4'd5
  };
  localparam kind_e KwKind [KwCount] = '{
    KIND_NUM, KIND_BOOL, KIND_STRING, KIND_MODULE, KIND_INPUT, KIND_OUTPUT,
    KIND_IF, KIND_ELIF, KIND_ELSE, KIND_WHILE, KIND_PRINT, KIND_TRUE, KIND_FALSE
  };

  // Keyword match of a finished word; identifier when nothing matches
  function automatic kind_e keyword_kind(input logic [15:0] len,
                                         input logic [KwBits-1:0] kbuf);
    kind_e kind;
    logic  found;
    kind  = KIND_IDENTIFIER;
    found = 1'b0;
    for (int k = 0; k < KwCount; k++) begin
      if (!found && len == 16'(KwLen[k]) && kbuf == KwText[k]) begin
        kind  = KwKind[k];
        found = 1'b1;
      end
    end
    return kind;
  endfunction

  // First character of a two-character operator: {hit, index}
  function automatic logic [3:0] op_lookup(input logic [7:0] c);
    logic [3:0] r;
    case (c)
      8'h3C:   r = 4'b1000;  // <
      8'h3E:   r = 4'b1001;  // >
      8'h3D:   r = 4'b1010;  // =
      8'h21:   r = 4'b1011;  // !
      8'h7C:   r = 4'b1100;  // |
      8'h26:   r = 4'b1101;  // &
      default: r = 4'b0000;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] op_second(input logic [2:0] p);
    logic [7:0] r;
    case (p)
      3'd4:    r = 8'h7C;
      3'd5:    r = 8'h26;
      default: r = 8'h3D;
    endcase
    return r;
  endfunction

  function automatic kind_e op_single(input logic [2:0] p);
    kind_e r;
    case (p)
      3'd1:    r = KIND_GT;
      3'd2:    r = KIND_ASSIGN;
      3'd3:    r = KIND_NOT;
      3'd4:    r = KIND_BITOR;
      3'd5:    r = KIND_BITAND;
      default: r = KIND_LT;
    endcase
    return r;
  endfunction

  function automatic kind_e op_double(input logic [2:0] p);
    kind_e r;
    case (p)
      3'd1:    r = KIND_GTE;
      3'd2:    r = KIND_EQUALITY;
      3'd3:    r = KIND_NE;
      3'd4:    r = KIND_LOGICOR;
      3'd5:    r = KIND_LOGICAND;
      default: r = KIND_LTE;
    endcase
    return r;
  endfunction

  // Single-character tokens: hit flag in bit 6
  function automatic logic [6:0] single_lookup(input logic [7:0] c);
    logic [6:0] r;
    case (c)
      8'h5E:   r = {1'b1, KIND_XOR};
      8'h2B:   r = {1'b1, KIND_ADD};
      8'h2D:   r = {1'b1, KIND_SUBTRACT};
      8'h2A:   r = {1'b1, KIND_MULTIPLY};
      8'h2F:   r = {1'b1, KIND_DIVIDE};
      8'h28:   r = {1'b1, KIND_LPAREN};
      8'h29:   r = {1'b1, KIND_RPAREN};
      8'h7B:   r = {1'b1, KIND_LBRACE};
      8'h7D:   r = {1'b1, KIND_RBRACE};
      8'h2C:   r = {1'b1, KIND_COMMA};
      8'h3B:   r = {1'b1, KIND_SEMICOLON};
      default: r = {1'b0, KIND_UNKNOWN};
    endcase
    return r;
  endfunction

endpackage

// File: rtl/stok_scanner.sv
// ----------------------------------------------------------------------------
// stok_scanner: scan state and token decode
// Updates the scan state on every accepted byte and forms up to two words.
// ----------------------------------------------------------------------------
module stok_scanner (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      byte_i,
  input  logic            cfg_we_i,
  input  logic [23:0]     cfg_wdata_i,
  output stok_pkg::push_t push_o
);
  import stok_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_OPER  = 3'd1,
    MODE_ZERO  = 3'd2,
    MODE_DEC   = 3'd3,
    MODE_BIN   = 3'd4,
    MODE_IDENT = 3'd5
  } mode_e;

  mode_e                 mode_q, mode_d;
  logic [2:0]            pend_q, pend_d;
  logic [30:0]           acc_q, acc_d;
  logic [KwBits-1:0]     kbuf_q, kbuf_d;
  logic [15:0]           ilen_q, ilen_d;
  logic [OffsetBits-1:0] istart_q, istart_d;
  logic [OffsetBits-1:0] pos_q, pos_d;
  logic [23:0]           line_q, line_d;
  logic [23:0]           line_start_q;
  logic                  fresh_q, fresh_d;

  logic       is_digit, is_alpha, is_word, is_bin;
  logic [3:0] op_hit;
  logic [6:0] single_hit;
  logic [2:0] pend_sel;
  logic [34:0] dec_mac;
  logic [31:0] bin_mac;
  logic [30:0] digit;
  kind_e      word_kind;
  logic       done;
  logic       m_valid, f_valid;
  token_t     m_tok, f_tok;

  // Character classes
  assign is_digit   = (byte_i >= ChZero) && (byte_i <= ChNine);
  assign is_alpha   = (byte_i >= 8'h61 && byte_i <= 8'h7A) ||
                      (byte_i >= 8'h41 && byte_i <= 8'h5A);
  assign is_word    = is_alpha || is_digit || (byte_i == ChUnder);
  assign is_bin     = (byte_i == ChZero) || (byte_i == ChOne);
  assign op_hit     = op_lookup(byte_i);
  assign single_hit = single_lookup(byte_i);
  assign pend_sel   = (pend_q < 3'd6) ? pend_q : 3'd0;
  assign digit      = 31'(byte_i - ChZero);

  // Saturating multiply-accumulate, x10 as shift-add
  assign dec_mac = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + 35'(digit);
  assign bin_mac = {acc_q, 1'b0} + 32'(digit);

  assign word_kind = keyword_kind(ilen_q, kbuf_q);

  function automatic token_t mk_tok(input kind_e kind, input logic [30:0] value,
                                    input logic [31:0] start, input logic [15:0] len,
                                    input logic [23:0] line);
    token_t t;
    t.kind  = kind;
    t.value = value;
    t.start = start;
    t.len   = len;
    t.line  = line;
    t.last  = 1'b0;
    return t;
  endfunction

  // Next state and the words for this byte
  always_comb begin
    mode_d   = mode_q;
    pend_d   = pend_q;
    acc_d    = acc_q;
    kbuf_d   = kbuf_q;
    ilen_d   = ilen_q;
    istart_d = istart_q;
    pos_d    = pos_q;
    line_d   = line_q;
    fresh_d  = 1'b0;
    done     = 1'b0;
    m_valid  = 1'b0;
    f_valid  = 1'b0;
    m_tok    = '0;
    f_tok    = '0;

    // Close out or extend the token in progress
    case (mode_q)
      MODE_OPER: begin
        m_valid = 1'b1;
        if (byte_i == op_second(pend_sel)) begin
          m_tok = mk_tok(op_double(pend_sel), '0, '0, '0, line_q);
          pos_d = pos_q + 1'b1;
          done  = 1'b1;
        end else begin
          m_tok = mk_tok(op_single(pend_sel), '0, '0, '0, line_q);
        end
        mode_d = MODE_IDLE;
      end
      MODE_ZERO: begin
        if (byte_i == ChLowB) begin
          mode_d = MODE_BIN;
          acc_d  = '0;
          pos_d  = pos_q + 1'b1;
          done   = 1'b1;
        end else if (is_digit) begin
          mode_d = MODE_DEC;
          acc_d  = digit;
          pos_d  = pos_q + 1'b1;
          done   = 1'b1;
        end else begin
          m_valid = 1'b1;
          m_tok   = mk_tok(KIND_NUMBER, acc_q, '0, '0, line_q);
          mode_d  = MODE_IDLE;
        end
      end
      MODE_DEC: begin
        if (is_digit) begin
          acc_d = (dec_mac > 35'(ValueMax)) ? ValueMax : dec_mac[30:0];
          pos_d = pos_q + 1'b1;
          done  = 1'b1;
        end else begin
          m_valid = 1'b1;
          m_tok   = mk_tok(KIND_NUMBER, acc_q, '0, '0, line_q);
          mode_d  = MODE_IDLE;
        end
      end
      MODE_BIN: begin
        if (is_bin) begin
          acc_d = (bin_mac > 32'(ValueMax)) ? ValueMax : bin_mac[30:0];
          pos_d = pos_q + 1'b1;
          done  = 1'b1;
        end else begin
          m_valid = 1'b1;
          m_tok   = mk_tok(KIND_NUMBER, acc_q, '0, '0, line_q);
          mode_d  = MODE_IDLE;
        end
      end
      MODE_IDENT: begin
        if (is_word) begin
          if (ilen_q < 16'(KwMaxChars)) kbuf_d = {kbuf_q[KwBits-9:0], byte_i};
          if (ilen_q != LenMax) ilen_d = ilen_q + 16'd1;
          pos_d = pos_q + 1'b1;
          done  = 1'b1;
        end else begin
          m_valid = 1'b1;
          m_tok   = mk_tok(word_kind, {30'd0, word_kind == KIND_TRUE},
                           32'(istart_q), ilen_q, line_q);
          mode_d  = MODE_IDLE;
        end
      end
      default: mode_d = MODE_IDLE;
    endcase

    // Scan the byte afresh
    if (!done) begin
      if (byte_i == ChNul) begin
        f_valid  = 1'b1;
        f_tok    = mk_tok(KIND_EOF, '0, '0, '0, line_q);
        mode_d   = MODE_IDLE;
        pend_d   = '0;
        acc_d    = '0;
        kbuf_d   = '0;
        ilen_d   = '0;
        istart_d = '0;
        pos_d    = '0;
        line_d   = line_start_q;
        fresh_d  = 1'b1;
      end else if (byte_i == ChLf) begin
        if (line_q != LineMax) line_d = line_q + 24'd1;
        pos_d = pos_q + 1'b1;
      end else if (byte_i == ChSpace || byte_i == ChTab || byte_i == ChCr) begin
        pos_d = pos_q + 1'b1;
      end else begin
        if (op_hit[3]) begin
          mode_d = MODE_OPER;
          pend_d = op_hit[2:0];
        end else if (single_hit[6]) begin
          f_valid = 1'b1;
          f_tok   = mk_tok(kind_e'(single_hit[5:0]), '0, '0, '0, line_q);
        end else if (is_digit) begin
          mode_d = (byte_i == ChZero) ? MODE_ZERO : MODE_DEC;
          acc_d  = digit;
        end else if (is_alpha || byte_i == ChUnder) begin
          mode_d   = MODE_IDENT;
          istart_d = pos_q;
          ilen_d   = 16'd1;
          kbuf_d   = KwBits'(byte_i);
        end else begin
          f_valid = 1'b1;
          f_tok   = mk_tok(KIND_UNKNOWN, '0, '0, '0, line_q);
        end
        pos_d = pos_q + 1'b1;
      end
    end

    // Compact into the push slots; the final word carries last
    m_tok.last = !f_valid;
    f_tok.last = 1'b1;
    if (m_valid) begin
      push_o.count = f_valid ? 2'd2 : 2'd1;
      push_o.tok0  = m_tok;
      push_o.tok1  = f_tok;
    end else begin
      push_o.count = f_valid ? 2'd1 : 2'd0;
      push_o.tok0  = f_tok;
      push_o.tok1  = '0;
    end
    if (!accept_i) push_o.count = 2'd0;
  end

  // Scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      pend_q       <= '0;
      acc_q        <= '0;
      kbuf_q       <= '0;
      ilen_q       <= '0;
      istart_q     <= '0;
      pos_q        <= '0;
      line_q       <= 24'd1;
      line_start_q <= 24'd1;
      fresh_q      <= 1'b1;
    end else begin
      if (cfg_we_i) line_start_q <= cfg_wdata_i;
      if (accept_i) begin
        mode_q   <= mode_d;
        pend_q   <= pend_d;
        acc_q    <= acc_d;
        kbuf_q   <= kbuf_d;
        ilen_q   <= ilen_d;
        istart_q <= istart_d;
        pos_q    <= pos_d;
        line_q   <= line_d;
        fresh_q  <= fresh_d;
      end else if (cfg_we_i && fresh_q) begin
        line_q <= cfg_wdata_i;
      end
    end
  end

`ifndef SYNTH
  a_eof_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && byte_i == ChNul |=> mode_q == MODE_IDLE && pos_q == '0 && fresh_q)
    else $error("scan state not restarted after end of source");
  a_ident_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_IDENT |-> ilen_q != '0)
    else $error("identifier in progress with zero length");
  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && byte_i == ChNul |-> push_o.count != 2'd0 &&
      (push_o.count == 2'd1 ? push_o.tok0.kind : push_o.tok1.kind) == KIND_EOF)
    else $error("end of source gave no trailing EOF word");
`endif

endmodule

// File: rtl/stok_out_fifo.sv
// ----------------------------------------------------------------------------
// stok_out_fifo: result word queue
// Takes up to two words per cycle, hands out one word per cycle while ready_i is high.
// ----------------------------------------------------------------------------
module stok_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stok_pkg::push_t  push_i,
  output logic             room_o,
  output logic             valid_o,
  input  logic             ready_i,
  output stok_pkg::token_t tok_o
);
  import stok_pkg::*;

  token_t             mem_q [FifoDepth];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] count_q;
  logic               pop;
  logic [PtrBits-1:0] wr_ptr_nx;

  assign pop       = valid_o && ready_i;
  assign valid_o   = count_q != '0;
  assign tok_o     = mem_q[rd_ptr_q];
  // Room for a full two-word push
  assign room_o    = count_q <= CntBits'(FifoDepth - 2);
  assign wr_ptr_nx = wr_ptr_q + 1'b1;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_ptr_q] <= push_i.tok0;
    if (push_i.count == 2'd2) mem_q[wr_ptr_nx] <= push_i.tok1;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrBits'(push_i.count);
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_q + CntBits'(push_i.count) - CntBits'(pop);
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count != 2'd0 |-> count_q + CntBits'(push_i.count) <= CntBits'(FifoDepth))
    else $error("result queue overflow");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(FifoDepth))
    else $error("result queue count out of range");
  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && push_i.count == 2'd0 |=> count_q == $past(count_q) - 1'b1)
    else $error("result queue count lost a pop");
`endif

endmodule

// File: rtl/source_tokenizer.sv
// ----------------------------------------------------------------------------
// source_tokenizer: byte-stream lexical analyzer
// Top level: stream ports, scanner and result queue.
// ----------------------------------------------------------------------------
// Source bytes enter on the slave stream, one byte per cycle when the result
// queue has room; a zero byte ends the source, flushes any pending token,
// emits EOF and restarts offset and line count. Each byte updates the scan
// state and yields zero, one or two token words into a four-entry result
// queue drained one word per cycle while the sink is ready. Throughput is
// one byte per cycle as long as the average does not exceed one token per
// byte; tready drops while the queue holds more than two words. tlast marks
// the final token word caused by a byte. line_start may be written only
// while the block is idle; it loads the line count right away if no byte of
// the current source has been taken, otherwise it applies from the next one.
module source_tokenizer (
  input  logic          clk_i,
  input  logic          rst_ni,
  // source bytes
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // [7:0] source_byte
  // token words
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [111:0]  m_axis_tdata,   // [5:0] token_kind, [36:6] number_value,
                                        // [68:37] text_start, [84:69] text_length,
                                        // [108:85] line_number, [111:109] zero
  output logic          m_axis_tlast,   // last_of_run
  // line_start register
  input  logic          cfg_we_i,
  input  logic [23:0]   cfg_wdata_i
);
  import stok_pkg::*;

  logic   accept;
  logic   room;
  push_t  push;
  token_t tok;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  stok_scanner u_scanner (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_o      (push)
  );

  stok_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .tok_o   (tok)
  );

  // Pack the word fields, lowest field first
  assign m_axis_tdata = {3'b000, tok.line, tok.len, tok.start, tok.value, tok.kind};
  assign m_axis_tlast = tok.last;

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the source tokenizer
// Feeds byte streams into the slave port and predicts every token word.
// Each word from the master port is checked field by field against the
// predicted order. It runs a directed opening, line saturation and long-word
// cases, then random sources under three idle profiles with one long stall.
// ----------------------------------------------------------------------------
module tb_top;
  import stok_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam int PhaseBytes = 630;
  localparam int DrainGuard = 8;

  // Scanner modes of the predictor
  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_OPER, SCAN_ZERO, SCAN_DEC, SCAN_BIN, SCAN_WORD
  } scan_e;

  // One predicted token word
  typedef struct packed {
    kind_e       kind;
    logic [30:0] value;
    logic [31:0] start;
    logic [15:0] len;
    logic [23:0] line;
    logic        last;
  } exp_tok_t;

  // Token predictor and expected-word store
  class token_check;
    string       kw_names [13];
    kind_e       kw_kinds [13];
    logic [23:0] line_start;
    logic [23:0] line_cnt;
    scan_e       mode;
    logic [7:0]  pend_lead;
    logic [30:0] acc;
    logic [47:0] kw_buf;
    logic [15:0] word_len;
    logic [31:0] word_start;
    logic [31:0] pos;
    bit          fresh;
    exp_tok_t    step_toks [$];
    exp_tok_t    expected_tokens [$];
    int          errors;

    function new();
      kw_names = '{"num", "bool", "string", "module", "input", "output",
                   "if", "elif", "else", "while", "print", "true", "false"};
      kw_kinds = '{KIND_NUM, KIND_BOOL, KIND_STRING, KIND_MODULE, KIND_INPUT,
                   KIND_OUTPUT, KIND_IF, KIND_ELIF, KIND_ELSE, KIND_WHILE,
                   KIND_PRINT, KIND_TRUE, KIND_FALSE};
      errors     = 0;
      line_start = 24'd1;
      restart();
    endfunction

    // Start state of a new source
    function void restart();
      mode       = SCAN_IDLE;
      pend_lead  = 8'h00;
      acc        = '0;
      kw_buf     = '0;
      word_len   = '0;
      word_start = '0;
      pos        = '0;
      line_cnt   = line_start;
      fresh      = 1'b1;
    endfunction

    function void set_line_start(logic [23:0] v);
      line_start = v;
      if (fresh) line_cnt = v;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= ChZero && c <= ChNine;
    endfunction

    function bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_word(logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == ChUnder;
    endfunction

    function bit pair_lead(logic [7:0] c);
      return c == "<" || c == ">" || c == "=" || c == "!" || c == "|" || c == "&";
    endfunction

    // Second character that completes a two-character operator
    function logic [7:0] pair_tail(logic [7:0] c);
      return (c == "|" || c == "&") ? c : 8'h3D;
    endfunction

    function kind_e pair_kind(logic [7:0] c, bit two);
      case (c)
        "<":     return two ? KIND_LTE : KIND_LT;
        ">":     return two ? KIND_GTE : KIND_GT;
        "=":     return two ? KIND_EQUALITY : KIND_ASSIGN;
        "!":     return two ? KIND_NE : KIND_NOT;
        "|":     return two ? KIND_LOGICOR : KIND_BITOR;
        default: return two ? KIND_LOGICAND : KIND_BITAND;
      endcase
    endfunction

    function bit single_tok(logic [7:0] c, output kind_e k);
      k = KIND_UNKNOWN;
      case (c)
        "^":     k = KIND_XOR;
        "+":     k = KIND_ADD;
        "-":     k = KIND_SUBTRACT;
        "*":     k = KIND_MULTIPLY;
        "/":     k = KIND_DIVIDE;
        "(":     k = KIND_LPAREN;
        ")":     k = KIND_RPAREN;
        "{":     k = KIND_LBRACE;
        "}":     k = KIND_RBRACE;
        ",":     k = KIND_COMMA;
        ";":     k = KIND_SEMICOLON;
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    // Multiply-accumulate of one digit, clamped at the value maximum
    function logic [30:0] mac_sat(logic [30:0] a, int unsigned base, logic [7:0] c);
      logic [63:0] v;
      v = 64'(a) * 64'(base) + 64'(c) - 64'(ChZero);
      return (v > 64'(ValueMax)) ? ValueMax : v[30:0];
    endfunction

    function void bump_pos();
      pos = pos + 32'd1;
    endfunction

    function void emit(kind_e k, logic [30:0] v, logic [31:0] s, logic [15:0] l);
      exp_tok_t t;
      t.kind  = k;
      t.value = v;
      t.start = s;
      t.len   = l;
      t.line  = line_cnt;
      t.last  = 1'b0;
      step_toks.push_back(t);
    endfunction

    // Finished word: keyword when short enough and matching, else identifier
    function void close_word();
      kind_e       k;
      logic [47:0] txt;
      int          n;
      k = KIND_IDENTIFIER;
      if (word_len <= 16'(KwMaxChars)) begin
        foreach (kw_names[i]) begin
          txt = '0;
          n   = kw_names[i].len();
          for (int j = 0; j < n; j++) txt = {txt[39:0], kw_names[i][j]};
          if (k == KIND_IDENTIFIER && word_len == 16'(n) && txt == kw_buf) k = kw_kinds[i];
        end
      end
      emit(k, (k == KIND_TRUE) ? 31'd1 : 31'd0, word_start, word_len);
    endfunction

    // Accepted source byte: advance the scan and queue the words it causes
    function void take_byte(logic [7:0] c);
      bit    done;
      kind_e k;
      done  = 1'b0;
      fresh = 1'b0;
      case (mode)
        SCAN_OPER: begin
          if (c == pair_tail(pend_lead)) begin
            emit(pair_kind(pend_lead, 1'b1), '0, '0, '0);
            bump_pos();
            done = 1'b1;
          end else begin
            emit(pair_kind(pend_lead, 1'b0), '0, '0, '0);
          end
          mode = SCAN_IDLE;
        end
        SCAN_ZERO: begin
          if (c == ChLowB) begin
            mode = SCAN_BIN;
            acc  = '0;
            bump_pos();
            done = 1'b1;
          end else if (is_digit(c)) begin
            mode = SCAN_DEC;
            acc  = 31'(c) - 31'(ChZero);
            bump_pos();
            done = 1'b1;
          end else begin
            emit(KIND_NUMBER, acc, '0, '0);
            mode = SCAN_IDLE;
          end
        end
        SCAN_DEC: begin
          if (is_digit(c)) begin
            acc = mac_sat(acc, 10, c);
            bump_pos();
            done = 1'b1;
          end else begin
            emit(KIND_NUMBER, acc, '0, '0);
            mode = SCAN_IDLE;
          end
        end
        SCAN_BIN: begin
          if (c == ChZero || c == ChOne) begin
            acc = mac_sat(acc, 2, c);
            bump_pos();
            done = 1'b1;
          end else begin
            emit(KIND_NUMBER, acc, '0, '0);
            mode = SCAN_IDLE;
          end
        end
        SCAN_WORD: begin
          if (is_word(c)) begin
            if (word_len < 16'(KwMaxChars)) kw_buf = {kw_buf[39:0], c};
            if (word_len != LenMax) word_len = word_len + 16'd1;
            bump_pos();
            done = 1'b1;
          end else begin
            close_word();
            mode = SCAN_IDLE;
          end
        end
        default: mode = SCAN_IDLE;
      endcase

      // Byte not consumed by a pending token: scan it afresh
      if (!done) begin
        if (c == ChNul) begin
          emit(KIND_EOF, '0, '0, '0);
          restart();
        end else if (c == ChLf) begin
          if (line_cnt != LineMax) line_cnt = line_cnt + 24'd1;
          bump_pos();
        end else if (c == ChSpace || c == ChTab || c == ChCr) begin
          bump_pos();
        end else begin
          if (pair_lead(c)) begin
            mode      = SCAN_OPER;
            pend_lead = c;
          end else if (single_tok(c, k)) begin
            emit(k, '0, '0, '0);
          end else if (is_digit(c)) begin
            mode = (c == ChZero) ? SCAN_ZERO : SCAN_DEC;
            acc  = 31'(c) - 31'(ChZero);
          end else if (is_alpha(c) || c == ChUnder) begin
            mode       = SCAN_WORD;
            word_start = pos;
            word_len   = 16'd1;
            kw_buf     = {40'h0, c};
          end else begin
            emit(KIND_UNKNOWN, '0, '0, '0);
          end
          bump_pos();
        end
      end

      if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
      foreach (step_toks[i]) expected_tokens.push_back(step_toks[i]);
      step_toks.delete();
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] token check error: %s", $time, msg);
    endtask

    // Accepted token word against the oldest prediction
    task check_token(logic [111:0] d, logic last);
      exp_tok_t e;
      if (expected_tokens.size() == 0) begin
        report($sformatf("token word %h with nothing predicted", d));
      end else begin
        e = expected_tokens.pop_front();
        if (d[5:0] != e.kind)
          report($sformatf("kind %0d, predicted %0d", d[5:0], e.kind));
        if (d[36:6] != e.value)
          report($sformatf("value %0d, predicted %0d", d[36:6], e.value));
        if (d[68:37] != e.start)
          report($sformatf("start %0d, predicted %0d", d[68:37], e.start));
        if (d[84:69] != e.len)
          report($sformatf("length %0d, predicted %0d", d[84:69], e.len));
        if (d[108:85] != e.line)
          report($sformatf("line %0d, predicted %0d", d[108:85], e.line));
        if (last != e.last)
          report($sformatf("tlast %0b, predicted %0b", last, e.last));
      end
    endtask
  endclass

  logic          clk_i         = 1'b0;
  logic          rst_ni        = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [7:0]    s_axis_tdata  = 8'h00;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [111:0]  m_axis_tdata;
  logic          m_axis_tlast;
  logic          cfg_we_i      = 1'b0;
  logic [23:0]   cfg_wdata_i   = 24'h0;

  token_check    sb = new();
  logic [7:0]    src_q [$];
  int            src_idle_pct = 0;
  int            snk_idle_pct = 0;
  bit            hold_req     = 1'b0;
  int            hold_left    = 0;
  int            cycles       = 0;

  source_tokenizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Handshake monitor: input words first, then token words
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.take_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_token(m_axis_tdata, m_axis_tlast);
    end
  end

  // Token receiver: random back-pressure, or a long hold when asked
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // One byte word, with random gaps before it; returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_all(input bit squeeze);
    foreach (src_q[i]) begin
      if (squeeze && i == 150) hold_req = 1'b1;
      send_byte(src_q[i]);
    end
    s_axis_tvalid <= 1'b0;
    src_q.delete();
  endtask

  // Wait for every predicted word, plus a margin for silent bytes in flight
  task automatic wait_drained();
    while (sb.expected_tokens.size() != 0) @(negedge clk_i);
    repeat (DrainGuard) @(negedge clk_i);
  endtask

  task automatic write_line_start(input logic [23:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_line_start(v);
  endtask

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) src_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 3))
      0:       return 8'("a" + $urandom_range(0, 25));
      1:       return 8'("A" + $urandom_range(0, 25));
      2:       return 8'(ChZero + $urandom_range(0, 9));
      default: return ChUnder;
    endcase
  endfunction

  function automatic logic [7:0] lead_char();
    case ($urandom_range(0, 2))
      0:       return 8'("a" + $urandom_range(0, 25));
      1:       return 8'("A" + $urandom_range(0, 25));
      default: return ChUnder;
    endcase
  endfunction

  // One random lexeme, mostly well formed, some noise and end-of-source
  function automatic void add_lexeme();
    string      txt;
    int         sel;
    int         n;
    logic [7:0] c;
    sel = $urandom_range(0, 99);
    if (sel < 14) begin
      // keyword, sometimes stretched into an identifier
      push_text(sb.kw_names[$urandom_range(0, 12)]);
      if ($urandom_range(0, 3) == 0) src_q.push_back(word_char());
    end else if (sel < 26) begin
      src_q.push_back(lead_char());
      n = $urandom_range(0, 8);
      repeat (n) src_q.push_back(word_char());
    end else if (sel < 38) begin
      // decimal, leading zero now and then, long ones saturate
      n = $urandom_range(1, 12);
      src_q.push_back(($urandom_range(0, 4) == 0) ? ChZero
                                                  : 8'(ChZero + $urandom_range(1, 9)));
      repeat (n - 1) src_q.push_back(8'(ChZero + $urandom_range(0, 9)));
    end else if (sel < 46) begin
      // binary, sometimes with no digit at all
      push_text("0b");
      n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 34);
      repeat (n) src_q.push_back(($urandom_range(0, 1) == 1) ? ChOne : ChZero);
    end else if (sel < 60) begin
      txt = "<>=!|&";
      c   = txt[$urandom_range(0, 5)];
      src_q.push_back(c);
      if ($urandom_range(0, 1) == 1) src_q.push_back((c == "|" || c == "&") ? c : 8'h3D);
    end else if (sel < 72) begin
      txt = "^+-*/(){},;";
      src_q.push_back(txt[$urandom_range(0, 10)]);
    end else if (sel < 88) begin
      case ($urandom_range(0, 3))
        0:       src_q.push_back(ChSpace);
        1:       src_q.push_back(ChTab);
        2:       src_q.push_back(ChCr);
        default: src_q.push_back(ChLf);
      endcase
    end else if (sel < 97) begin
      src_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      src_q.push_back(ChNul);
    end
  endfunction

  task automatic run_random(input int src_pct, input int snk_pct, input bit squeeze);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    while (src_q.size() < PhaseBytes) add_lexeme();
    send_all(squeeze);
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Opening: empty binary, leading zero, overflow, operators, high bytes
    push_text("0b;07 9999999999<=&&|x");
    src_q.push_back(8'hFF);
    src_q.push_back(8'h80);
    push_text(" true");
    src_q.push_back(ChLf);
    src_q.push_back(ChNul);
    send_all(1'b0);

    // Line count saturation, source left open
    write_line_start(24'hFF_FFFE);
    repeat (3) src_q.push_back(ChLf);
    push_text(";");
    send_all(1'b0);

    // Write mid-source takes effect at the next source; then a long word
    write_line_start(24'h0);
    src_q.push_back(ChNul);
    src_q.push_back(ChUnder);
    repeat (40) src_q.push_back(word_char());
    push_text(";");
    src_q.push_back(ChNul);
    send_all(1'b0);

    write_line_start(LineMax);
    run_random(34, 53, 1'b0);
    write_line_start(24'($urandom()));
    run_random(53, 34, 1'b0);
    write_line_start(24'd1);
    run_random(0, 0, 1'b1);

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/stok_pkg.sv
rtl/stok_scanner.sv
rtl/stok_out_fifo.sv
rtl/source_tokenizer.sv
dv/tb_top.sv
